/* sv/scwr_pkg.sv */
// Shared types, codes and constants of the sparse column weight reducer.
package scwr_pkg;

    // Reduction selected by the mode register.
    localparam logic [2:0] MODE_WSUM = 3'd0;
    localparam logic [2:0] MODE_SUM  = 3'd1;
    localparam logic [2:0] MODE_MEAN = 3'd2;
    localparam logic [2:0] MODE_MIN  = 3'd3;
    localparam logic [2:0] MODE_MAX  = 3'd4;
    localparam logic [2:0] MODE_DIAG = 3'd5;
    localparam logic [2:0] MODE_RESET = MODE_SUM;

    localparam int DEF_ROW_INDEX_BITS = 20;
    localparam int DEF_VALUE_BITS     = 32;

    localparam int WEIGHT_W   = 64;
    localparam int OUT_COL_W  = 20;
    localparam int OUT_DATA_W = ((WEIGHT_W + OUT_COL_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - WEIGHT_W - OUT_COL_W;
    localparam int OUT_USER_W = 2;

    localparam int COUNT_W = 21;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int DIV_STEPS = WEIGHT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [WEIGHT_W-1:0] WMAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] WMIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_empty;
        logic fold;
        logic mul_load;
        logic mul_comb;
        logic mul_add;
        logic div_init;
        logic div_step;
        logic emit;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic mode_wsum;
        logic mode_mean;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

/* sv/scwr_divider.sv */
// Restoring divider that produces one quotient bit per cycle while i_step is high.
module scwr_divider
    import scwr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_init,
    input  logic                i_step,
    input  logic [WEIGHT_W-1:0] i_dividend,
    input  logic [COUNT_W-1:0]  i_divisor,
    output logic [WEIGHT_W-1:0] o_quotient,
    output logic                o_last_step
);

    logic [WEIGHT_W-1:0]  r_quo;
    logic [COUNT_W-1:0]   r_rem;
    logic [COUNT_W-1:0]   r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [COUNT_W:0]     rem_sh;
    logic                 ge;
    logic [COUNT_W:0]     rem_sub;

    assign rem_sh  = {r_rem, r_quo[WEIGHT_W-1]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_init) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (i_step) begin
            r_quo <= {r_quo[WEIGHT_W-2:0], ge};
            r_rem <= ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_last_step = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

/* sv/scwr_dpath.sv */
// Datapath: mode register, column state, weighted product, mean divider, output register.
module scwr_dpath
    import scwr_pkg::*;
#(
    parameter int ROW_INDEX_BITS = DEF_ROW_INDEX_BITS,
    parameter int VALUE_BITS     = DEF_VALUE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_stat                     o_stat,
    input  logic                      i_cfg_wen,
    input  logic [2:0]                i_cfg_wdata,
    input  logic [ROW_INDEX_BITS-1:0] i_row,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                      i_m_tready,
    output logic                      o_out_valid,
    output logic [WEIGHT_W-1:0]       o_weight,
    output logic [OUT_COL_W-1:0]      o_col,
    output logic                      o_was_empty,
    output logic                      o_sat
);

    localparam int HB     = (VALUE_BITS + 1) / 2;
    localparam int HI_B   = VALUE_BITS - HB;
    localparam int LO_W   = HB + ROW_INDEX_BITS;
    localparam int HI_W   = HI_B + ROW_INDEX_BITS;
    localparam int PROD_W = VALUE_BITS + ROW_INDEX_BITS;
    localparam int EXT_W  = (PROD_W > WEIGHT_W) ? PROD_W : WEIGHT_W + 1;

    function automatic logic [WEIGHT_W:0] sat_add(input logic [WEIGHT_W-1:0] a,
                                                  input logic [WEIGHT_W-1:0] b);
        logic [WEIGHT_W-1:0] s;
        logic                ov;
        s  = a + b;
        ov = (a[WEIGHT_W-1] == b[WEIGHT_W-1]) && (s[WEIGHT_W-1] != a[WEIGHT_W-1]);
        if (ov) begin
            return {1'b1, a[WEIGHT_W-1] ? WMIN : WMAX};
        end
        return {1'b0, s};
    endfunction

    logic [2:0]                r_mode;
    logic [ROW_INDEX_BITS-1:0] r_col;
    logic [WEIGHT_W-1:0]       r_acc;
    logic [WEIGHT_W-1:0]       n_acc;
    logic [COUNT_W-1:0]        r_count;
    logic signed [VALUE_BITS-1:0] r_ext;
    logic                      r_first;
    logic                      r_diag;
    logic                      n_diag;
    logic                      r_ovf;
    logic                      n_ovf;
    logic                      r_empty_pend;
    logic [LO_W-1:0]           r_pp_lo;
    logic [HI_W-1:0]           r_pp_hi;
    logic                      r_neg;
    logic [WEIGHT_W-1:0]       r_pmag;
    logic                      r_povf;
    logic                      r_mean_neg;
    logic                      r_out_valid;
    logic [WEIGHT_W-1:0]       r_out_weight;
    logic [OUT_COL_W-1:0]      r_out_col;
    logic                      r_out_empty;
    logic                      r_out_sat;

    logic [WEIGHT_W-1:0]       val64;
    logic [VALUE_BITS-1:0]     mag;
    logic [EXT_W-1:0]          p_full;
    logic [EXT_W-1:0]          p_lim;
    logic                      p_over;
    logic [WEIGHT_W-1:0]       addend;
    logic [WEIGHT_W:0]         add_v;
    logic [WEIGHT_W:0]         add_p;
    logic                      cnt_sat;
    logic                      out_free;
    logic [WEIGHT_W-1:0]       dividend;
    logic [WEIGHT_W-1:0]       quotient;
    logic                      div_last;
    logic [WEIGHT_W-1:0]       mean_w;

    assign val64   = {{(WEIGHT_W-VALUE_BITS){i_value[VALUE_BITS-1]}}, i_value};
    assign mag     = i_value[VALUE_BITS-1] ? (VALUE_BITS'(0) - i_value) : i_value;
    assign cnt_sat = (r_count == COUNT_MAX);
    assign out_free = !r_out_valid || i_m_tready;

    // Product of magnitude and row: recombine the two partial products, then clamp.
    assign p_full = (EXT_W'(r_pp_hi) << HB) + EXT_W'(r_pp_lo);
    assign p_lim  = EXT_W'(WMAX) + EXT_W'(r_neg);
    assign p_over = p_full > p_lim;
    assign addend = r_neg ? (WEIGHT_W'(0) - r_pmag) : r_pmag;

    assign add_v = sat_add(r_acc, val64);
    assign add_p = sat_add(r_acc, addend);

    always_comb begin
        n_acc  = r_acc;
        n_ovf  = r_ovf;
        n_diag = r_diag;
        if ((i_cmd.fold || i_cmd.mul_load) && cnt_sat) begin
            n_ovf = 1'b1;
        end
        if (i_cmd.fold) begin
            if (r_mode == MODE_DIAG) begin
                if (!r_diag) begin
                    if (i_row == r_col) begin
                        n_acc  = val64;
                        n_diag = 1'b1;
                        n_ovf  = 1'b0;
                    end else begin
                        n_acc = add_v[WEIGHT_W-1:0];
                        n_ovf = n_ovf | add_v[WEIGHT_W];
                    end
                end
            end else begin
                n_acc = add_v[WEIGHT_W-1:0];
                n_ovf = n_ovf | add_v[WEIGHT_W];
            end
        end
        if (i_cmd.mul_add) begin
            n_acc = add_p[WEIGHT_W-1:0];
            n_ovf = r_ovf | r_povf | add_p[WEIGHT_W];
        end
        if (i_cmd.emit) begin
            n_acc  = '0;
            n_ovf  = 1'b0;
            n_diag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_RESET;
            r_col        <= '0;
            r_acc        <= '0;
            r_count      <= '0;
            r_ext        <= '0;
            r_first      <= 1'b1;
            r_diag       <= 1'b0;
            r_ovf        <= 1'b0;
            r_empty_pend <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
            r_diag <= n_diag;
            if (i_cfg_wen && (i_cfg_wdata <= MODE_DIAG)) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_cmd.take_empty) begin
                r_empty_pend <= 1'b1;
            end
            if (i_cmd.fold || i_cmd.mul_load) begin
                if (!cnt_sat) begin
                    r_count <= r_count + COUNT_W'(1);
                end
                if (r_first) begin
                    r_ext   <= i_value;
                    r_first <= 1'b0;
                end else if ((r_mode == MODE_MIN) && (i_value < r_ext)) begin
                    r_ext <= i_value;
                end else if ((r_mode == MODE_MAX) && (r_ext < i_value)) begin
                    r_ext <= i_value;
                end
            end
            if (i_cmd.emit) begin
                r_col        <= r_col + ROW_INDEX_BITS'(1);
                r_count      <= '0;
                r_ext        <= '0;
                r_first      <= 1'b1;
                r_empty_pend <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_pp_lo <= LO_W'(mag[HB-1:0]) * LO_W'(i_row);
            r_pp_hi <= HI_W'(mag[VALUE_BITS-1:HB]) * HI_W'(i_row);
            r_neg   <= i_value[VALUE_BITS-1];
        end
        if (i_cmd.mul_comb) begin
            r_pmag <= p_over ? p_lim[WEIGHT_W-1:0] : p_full[WEIGHT_W-1:0];
            r_povf <= p_over;
        end
        if (i_cmd.div_init) begin
            r_mean_neg <= r_acc[WEIGHT_W-1];
        end
    end

    // Ceiling mean: a positive sum is biased by count-1, a negative sum
    // truncates its magnitude, which rounds toward plus infinity.
    assign dividend = r_acc[WEIGHT_W-1] ? (WEIGHT_W'(0) - r_acc)
                                        : (r_acc + WEIGHT_W'(r_count) - WEIGHT_W'(1));
    assign mean_w   = r_mean_neg ? (WEIGHT_W'(0) - quotient) : quotient;

    scwr_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init      (i_cmd.div_init),
        .i_step      (i_cmd.div_step),
        .i_dividend  (dividend),
        .i_divisor   (r_count),
        .o_quotient  (quotient),
        .o_last_step (div_last)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_col <= OUT_COL_W'(r_col);
            if (r_empty_pend) begin
                r_out_weight <= '0;
                r_out_empty  <= 1'b1;
                r_out_sat    <= 1'b0;
            end else begin
                r_out_empty <= 1'b0;
                case (r_mode) inside
                    MODE_MEAN: begin
                        r_out_weight <= mean_w;
                        r_out_sat    <= r_ovf;
                    end
                    MODE_MIN, MODE_MAX: begin
                        r_out_weight <= {{(WEIGHT_W-VALUE_BITS){r_ext[VALUE_BITS-1]}}, r_ext};
                        r_out_sat    <= 1'b0;
                    end
                    default: begin
                        r_out_weight <= r_acc;
                        r_out_sat    <= r_ovf;
                    end
                endcase
            end
        end
    end

    assign o_stat.mode_wsum = (r_mode == MODE_WSUM);
    assign o_stat.mode_mean = (r_mode == MODE_MEAN);
    assign o_stat.div_done  = div_last;
    assign o_stat.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_weight    = r_out_weight;
    assign o_col       = r_out_col;
    assign o_was_empty = r_out_empty;
    assign o_sat       = r_out_sat;

endmodule

/* sv/scwr_ctrl.sv */
// Controller state machine that sequences folding, multiply, division and result load.
module scwr_ctrl
    import scwr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  logic  i_s_tlast,
    input  logic  i_s_tuser,
    input  t_stat i_stat,
    output logic  o_s_tready,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_MADD  = 3'd2;
    localparam logic [2:0] S_DINIT = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_last_pend;
    logic       n_last_pend;

    always_comb begin
        n_state     = r_state;
        n_last_pend = r_last_pend;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_s_tuser) begin
                        o_cmd.take_empty = 1'b1;
                        n_state          = S_EMIT;
                    end else if (i_stat.mode_wsum) begin
                        o_cmd.mul_load = 1'b1;
                        n_last_pend    = i_s_tlast;
                        n_state        = S_MUL;
                    end else begin
                        o_cmd.fold = 1'b1;
                        if (i_s_tlast) begin
                            n_state = i_stat.mode_mean ? S_DINIT : S_EMIT;
                        end
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_comb = 1'b1;
                n_state        = S_MADD;
            end
            S_MADD: begin
                o_cmd.mul_add = 1'b1;
                n_state       = r_last_pend ? S_EMIT : S_IDLE;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_pend <= n_last_pend;
        end
    end

endmodule

/* sv/sparse_column_weight_reducer_unit.sv */
// Top level of the sparse column weight reducer: stream ports, controller and datapath.
//
//  Channel   Direction  Handshake                Contents
//  s_axis    in         i_s_tvalid / o_s_tready  one nonzero entry, or an empty-column marker
//  m_axis    out        o_m_tvalid / i_m_tready  one weight for each finished column
//  cfg       in         i_cfg_wen                weight_mode, no read-back
//
//  In modes 1 to 5 an entry is folded in as it is accepted; the weighted-sum mode takes
//  it through split multiply, recombine and clamp, and saturating accumulate steps.
//  Closing a column adds the result load; the mean mode adds a divider set-up step and
//  the divider, retiring one quotient bit per cycle. An empty item goes straight to the result load.
//  Reset is synchronous, active low: mode 1, column number 0, no result pending.
//  A stalled output holds the block in its result-load step; new entries then wait.
module sparse_column_weight_reducer_unit
    import scwr_pkg::*;
#(
    parameter int ROW_INDEX_BITS = DEF_ROW_INDEX_BITS,
    parameter int VALUE_BITS     = DEF_VALUE_BITS,
    localparam int IN_DATA_W     = ((ROW_INDEX_BITS + VALUE_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input beat: [ROW_INDEX_BITS-1:0] row_index, then entry_value, zero padding above.
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic                  i_s_tlast,   // last_in_column
    input  logic                  i_s_tuser,   // empty_column
    // Output beat: [63:0] column_weight, [83:64] column_number, zero padding above.
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // Output flags: [0] was_empty, [1] saturated.
    output logic [OUT_USER_W-1:0] o_m_tuser,
    input  logic                  i_cfg_wen,
    input  logic [2:0]            i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    logic [ROW_INDEX_BITS-1:0]    in_row;
    logic signed [VALUE_BITS-1:0] in_value;
    logic [WEIGHT_W-1:0]          out_weight;
    logic [OUT_COL_W-1:0]         out_col;
    logic                         out_empty;
    logic                         out_sat;

    // Unpack the input beat; the padding bits above the value carry nothing.
    assign in_row   = i_s_tdata[ROW_INDEX_BITS-1:0];
    assign in_value = i_s_tdata[ROW_INDEX_BITS+VALUE_BITS-1:ROW_INDEX_BITS];

    // The controller decides per beat which datapath step runs; the mode
    // register lives in the datapath and reports back through the status.
    scwr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    scwr_dpath #(
        .ROW_INDEX_BITS (ROW_INDEX_BITS),
        .VALUE_BITS     (VALUE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_row       (in_row),
        .i_value     (in_value),
        .i_m_tready  (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_weight    (out_weight),
        .o_col       (out_col),
        .o_was_empty (out_empty),
        .o_sat       (out_sat)
    );

    // Pack the result beat from the output register.
    assign o_m_tdata = {{OUT_PAD_W{1'b0}}, out_col, out_weight};
    assign o_m_tuser = {out_sat, out_empty};

endmodule

/* sv/scwr_checker.sv */
// Port-level assertions for the sparse column weight reducer and their bind.
module scwr_checker
    import scwr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  i_s_tlast,
    input logic                  i_s_tuser,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_USER_W-1:0] o_m_tuser
);

    // A pending result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result beat withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result beat changed while stalled");

    // An empty column reports weight zero and never a clamp.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> ((o_m_tdata[WEIGHT_W-1:0] == '0) && !o_m_tuser[1]))
        else $error("empty column with nonzero weight or saturation");

    // A beat that closes a column moves the block out of its idle state, so input is not ready right after it.
    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tlast || i_s_tuser)) |=> !o_s_tready)
        else $error("input accepted right after a column close");

endmodule

bind sparse_column_weight_reducer_unit scwr_checker u_scwr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .i_s_tuser  (i_s_tuser),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tuser  (o_m_tuser)
);
